### rtl/core/neighbor_joining_tree_defines.svh
// ----------------------------------------------------------------------------
// neighbor_joining_tree_defines.svh
// assertion macros for the checker file of the joining tree block
// ----------------------------------------------------------------------------
`ifndef NEIGHBOR_JOINING_TREE_DEFINES_SVH
`define NEIGHBOR_JOINING_TREE_DEFINES_SVH

// same-cycle implication, reset held low disables the check
`define NJT_ASSERT_NOW(name, clk, rstn, ante, cons) \
  name: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error("njt check failed");

// next-cycle implication
`define NJT_ASSERT_NEXT(name, clk, rstn, ante, cons) \
  name: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error("njt check failed");

`endif

### rtl/core/njt_pkg.sv
// ----------------------------------------------------------------------------
// njt_pkg
// shared widths, datapath commands and arithmetic helpers of the joining tree
// ----------------------------------------------------------------------------
`default_nettype none

package njt_pkg;

  localparam int MAX_SEQS   = 32;
  localparam int IDX_W      = 5;
  localparam int CNT_W      = 6;
  localparam int DIST_BITS  = 16;
  localparam int VAL_W      = 20;
  localparam int SUM_W      = 25;
  localparam int WIDE_W     = 28;
  localparam int LAB_W      = 6;
  localparam int ADDR_W     = 2 * IDX_W;
  localparam int MIN_SEQS   = 3;
  localparam int RESET_SEQS = 4;

  typedef enum logic [4:0] {
    OP_NONE, OP_INIT, OP_LOAD_A, OP_LOAD_B, OP_COPY_RD, OP_COPY_WR,
    OP_SUM_RD, OP_SUM_ACC, OP_DIV_START, OP_AVG_WR, OP_RI_RD, OP_RI_LD,
    OP_Q_RD, OP_Q_CMP, OP_DIJ_RD, OP_DIJ_LD, OP_LAB_A, OP_BR, OP_EMIT,
    OP_ND_RD1, OP_ND_LD1, OP_ND_RD2, OP_ND_WR, OP_CMP_RD, OP_CMP_WR,
    OP_LAB_SHIFT, OP_NN_RD, OP_NN_WR1, OP_NN_WR2, OP_DIAG, OP_FINAL_SEL,
    OP_EMIT_LAST
  } op_e;

  typedef struct packed {
    op_e              op;
    logic [IDX_W-1:0] i;
    logic [IDX_W-1:0] j;
    logic [CNT_W-1:0] k;
    logic             first;
  } cmd_t;

  typedef struct packed {
    logic div_busy;
    logic out_free;
    logic out_busy;
  } status_t;

  function automatic logic signed [VAL_W-1:0] sat_val(input logic signed [WIDE_W-1:0] v);
    logic signed [WIDE_W-1:0] hi;
    logic signed [WIDE_W-1:0] lo;
    logic signed [VAL_W-1:0]  r;
    hi = {{(WIDE_W-VAL_W+1){1'b0}}, {(VAL_W-1){1'b1}}};
    lo = {{(WIDE_W-VAL_W+1){1'b1}}, {(VAL_W-1){1'b0}}};
    if (v > hi) begin
      r = {1'b0, {(VAL_W-1){1'b1}}};
    end else if (v < lo) begin
      r = {1'b1, {(VAL_W-1){1'b0}}};
    end else begin
      r = v[VAL_W-1:0];
    end
    return r;
  endfunction

  // halve, rounding toward zero
  function automatic logic signed [WIDE_W-1:0] half_tz(input logic signed [WIDE_W-1:0] v);
    logic signed [WIDE_W-1:0] t;
    t = v + $signed({{(WIDE_W-1){1'b0}}, v[WIDE_W-1]});
    return t >>> 1;
  endfunction

endpackage

`default_nettype wire

### rtl/core/njt_ram.sv
// ----------------------------------------------------------------------------
// njt_ram
// generic single write port, single read port ram with registered read
// ----------------------------------------------------------------------------
`default_nettype none

module njt_ram #(
  parameter int WIDTH  = 8,
  parameter int DEPTH  = 32,
  parameter int ADDR_W = $clog2(DEPTH)
) (
  input  wire logic              clk_i,
  input  wire logic              we_i,
  input  wire logic [ADDR_W-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]  wdata_i,
  input  wire logic              re_i,
  input  wire logic [ADDR_W-1:0] raddr_i,
  output      logic [WIDTH-1:0]  rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule

`default_nettype wire

### rtl/core/njt_div.sv
// ----------------------------------------------------------------------------
// njt_div
// restoring divider, one quotient bit a cycle, truncates toward zero
// ----------------------------------------------------------------------------
`default_nettype none

module njt_div (
  input  wire logic                              clk_i,
  input  wire logic                              rst_ni,
  input  wire logic                              start_i,
  input  wire logic signed [njt_pkg::SUM_W-1:0]  dividend_i,
  input  wire logic        [njt_pkg::IDX_W-1:0]  divisor_i,
  output      logic                              busy_o,
  output      logic signed [njt_pkg::SUM_W-1:0]  quot_o
);
  import njt_pkg::*;

  localparam int CW = $clog2(SUM_W);

  logic             busy_q;
  logic [CW-1:0]    cnt_q;
  logic             neg_q;
  logic [SUM_W-1:0] sh_q;
  logic [IDX_W-1:0] rem_q;
  logic [IDX_W-1:0] dvs_q;
  logic [IDX_W:0]   trial;
  logic             fits;

  assign trial = {rem_q, sh_q[SUM_W-1]};
  assign fits  = trial >= {1'b0, dvs_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
    end else if (start_i) begin
      busy_q <= 1'b1;
      cnt_q  <= '0;
    end else if (busy_q) begin
      cnt_q <= cnt_q + 1'b1;
      if (cnt_q == CW'(SUM_W - 1)) begin
        busy_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      neg_q <= dividend_i[SUM_W-1];
      sh_q  <= dividend_i[SUM_W-1] ? -dividend_i : dividend_i;
      rem_q <= '0;
      dvs_q <= divisor_i;
    end else if (busy_q) begin
      rem_q <= fits ? IDX_W'(trial - {1'b0, dvs_q}) : trial[IDX_W-1:0];
      sh_q  <= {sh_q[SUM_W-2:0], fits};
    end
  end

  assign busy_o = busy_q;
  assign quot_o = neg_q ? -$signed(sh_q) : $signed(sh_q);

endmodule

`default_nettype wire

### rtl/core/njt_dp.sv
// ----------------------------------------------------------------------------
// njt_dp
// joining tree datapath: matrices, row averages, minimum search, output beat
// ----------------------------------------------------------------------------
`default_nettype none

module njt_dp (
  input  wire logic                              clk_i,
  input  wire logic                              rst_ni,
  input  wire njt_pkg::cmd_t                     cmd_i,
  output      njt_pkg::status_t                  status_o,
  input  wire logic                              in_accept_i,
  input  wire logic [njt_pkg::IDX_W-1:0]         row_i,
  input  wire logic [njt_pkg::IDX_W-1:0]         col_i,
  input  wire logic [njt_pkg::DIST_BITS-1:0]     distance_i,
  input  wire logic                              out_ready_i,
  output      logic                              out_valid_o,
  output      logic [njt_pkg::LAB_W-1:0]         node_a_o,
  output      logic [njt_pkg::LAB_W-1:0]         node_b_o,
  output      logic signed [njt_pkg::VAL_W-1:0]  pair_distance_o,
  output      logic signed [njt_pkg::VAL_W-1:0]  branch_a_o,
  output      logic signed [njt_pkg::VAL_W-1:0]  branch_b_o,
  output      logic                              last_o
);
  import njt_pkg::*;

  logic [IDX_W-1:0]     row_q, col_q;
  logic [DIST_BITS-1:0] dist_q;

  logic                 d_we, d_re;
  logic [ADDR_W-1:0]    d_waddr, d_raddr;
  logic [VAL_W-1:0]     d_wdata, d_rdata;
  logic                 w_we, w_re;
  logic [ADDR_W-1:0]    w_waddr, w_raddr;
  logic [VAL_W-1:0]     w_wdata, w_rdata;
  logic                 a_we, a_re;
  logic [IDX_W-1:0]     a_waddr, a_raddr;
  logic [SUM_W-1:0]     a_rdata;
  logic                 n_we, n_re;
  logic [IDX_W-1:0]     n_waddr, n_raddr;
  logic [VAL_W-1:0]     n_wdata, n_rdata;

  logic signed [VAL_W-1:0]  w_rd_s;
  logic signed [SUM_W-1:0]  a_rd_s;
  logic signed [SUM_W-1:0]  sum_q, ri_q, rpi_q, rpj_q;
  logic signed [WIDE_W-1:0] best_q, q_val, dik_q, nd_val, br_val;
  logic signed [VAL_W-1:0]  dij_q, t_q;
  logic [IDX_W-1:0]         pi_q, pj_q, lo, hi, km2, map_i, map_j, lab_sel;
  logic [CNT_W-1:0]         km2_w;
  logic [LAB_W-1:0]         lab_q [MAX_SEQS];
  logic [LAB_W-1:0]         lab_pad [MAX_SEQS+2];
  logic [LAB_W-1:0]         lab_mux, lab_a_q, next_label_q;
  logic                     div_busy;
  logic signed [SUM_W-1:0]  quot;

  function automatic logic [IDX_W-1:0] map_idx(input logic [IDX_W-1:0] x,
                                               input logic [IDX_W-1:0] l,
                                               input logic [IDX_W-1:0] h);
    logic [IDX_W:0] s;
    s = {1'b0, x} + {{IDX_W{1'b0}}, (x >= l)}
        + {{IDX_W{1'b0}}, (({1'b0, x} + 1'b1) >= {1'b0, h})};
    return s[IDX_W-1:0];
  endfunction

  assign w_rd_s  = $signed(w_rdata);
  assign a_rd_s  = $signed(a_rdata);
  assign lo      = (pi_q < pj_q) ? pi_q : pj_q;
  assign hi      = (pi_q < pj_q) ? pj_q : pi_q;
  assign km2_w   = cmd_i.k - CNT_W'(2);
  assign km2     = km2_w[IDX_W-1:0];
  assign map_i   = map_idx(cmd_i.i, lo, hi);
  assign map_j   = map_idx(cmd_i.j, lo, hi);
  assign lab_sel = (cmd_i.op == OP_LAB_A) ? pi_q : pj_q;
  assign lab_mux = lab_q[lab_sel];

  assign q_val  = WIDE_W'(w_rd_s) - WIDE_W'(ri_q) - WIDE_W'(a_rd_s);
  assign nd_val = half_tz(WIDE_W'(t_q) + WIDE_W'(w_rd_s) - WIDE_W'(dij_q));
  assign br_val = half_tz(WIDE_W'(dij_q) + WIDE_W'(rpi_q) - WIDE_W'(rpj_q));

  always_comb begin
    for (int x = 0; x < MAX_SEQS; x++) begin
      lab_pad[x] = lab_q[x];
    end
    lab_pad[MAX_SEQS]   = '0;
    lab_pad[MAX_SEQS+1] = '0;
  end

  always_comb begin
    d_we = 1'b0; d_waddr = {row_q, col_q};
    d_wdata = {{(VAL_W-DIST_BITS){1'b0}}, dist_q};
    d_re = 1'b0; d_raddr = {cmd_i.i, cmd_i.j};
    w_we = 1'b0; w_waddr = {cmd_i.i, cmd_i.j}; w_wdata = '0;
    w_re = 1'b0; w_raddr = {cmd_i.i, cmd_i.j};
    a_we = 1'b0; a_waddr = cmd_i.i; a_re = 1'b0; a_raddr = cmd_i.i;
    n_we = 1'b0; n_waddr = cmd_i.i; n_wdata = sat_val(nd_val);
    n_re = 1'b0; n_raddr = map_i;
    case (cmd_i.op)
      OP_LOAD_A: d_we = 1'b1;
      OP_LOAD_B: begin
        d_we    = 1'b1;
        d_waddr = {col_q, row_q};
      end
      OP_COPY_RD: d_re = 1'b1;
      OP_COPY_WR: begin
        w_we    = 1'b1;
        w_wdata = (cmd_i.i == cmd_i.j) ? '0 : d_rdata;
      end
      OP_SUM_RD:  w_re = 1'b1;
      OP_AVG_WR:  a_we = 1'b1;
      OP_RI_RD:   a_re = 1'b1;
      OP_Q_RD: begin
        w_re    = 1'b1;
        a_re    = 1'b1;
        a_raddr = cmd_i.j;
      end
      OP_DIJ_RD: begin
        w_re    = 1'b1;
        w_raddr = {pi_q, pj_q};
      end
      OP_ND_RD1: begin
        w_re    = 1'b1;
        w_raddr = {pi_q, cmd_i.i};
      end
      OP_ND_RD2: begin
        w_re    = 1'b1;
        w_raddr = {pj_q, cmd_i.i};
      end
      OP_ND_WR:  n_we = 1'b1;
      OP_CMP_RD: begin
        w_re    = 1'b1;
        w_raddr = {map_i, map_j};
      end
      OP_CMP_WR: begin
        w_we    = 1'b1;
        w_wdata = (cmd_i.i == cmd_i.j) ? '0 : w_rdata;
      end
      OP_NN_RD:  n_re = 1'b1;
      OP_NN_WR1: begin
        w_we    = 1'b1;
        w_waddr = {km2, cmd_i.i};
        w_wdata = n_rdata;
      end
      OP_NN_WR2: begin
        w_we    = 1'b1;
        w_waddr = {cmd_i.i, km2};
        w_wdata = n_rdata;
      end
      OP_DIAG: begin
        w_we    = 1'b1;
        w_waddr = {km2, km2};
      end
      default: ;
    endcase
  end

  // control state: labels and the output beat
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_o  <= 1'b0;
      next_label_q <= '0;
      for (int x = 0; x < MAX_SEQS; x++) begin
        lab_q[x] <= LAB_W'(x);
      end
    end else begin
      if (cmd_i.op == OP_EMIT || cmd_i.op == OP_EMIT_LAST) begin
        out_valid_o <= 1'b1;
      end else if (out_valid_o && out_ready_i) begin
        out_valid_o <= 1'b0;
      end
      case (cmd_i.op)
        OP_INIT: begin
          next_label_q <= cmd_i.k;
          for (int x = 0; x < MAX_SEQS; x++) begin
            lab_q[x] <= LAB_W'(x);
          end
        end
        OP_LAB_SHIFT: begin
          next_label_q <= next_label_q + 1'b1;
          for (int x = 0; x < MAX_SEQS; x++) begin
            if (CNT_W'(x) < km2_w) begin
              lab_q[x] <= lab_pad[x + ((IDX_W'(x) >= lo) ? 1 : 0)
                                  + (((IDX_W+1)'(x) + 1'b1 >= {1'b0, hi}) ? 1 : 0)];
            end else if (CNT_W'(x) == km2_w) begin
              lab_q[x] <= next_label_q;
            end
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_accept_i) begin
      row_q  <= row_i;
      col_q  <= col_i;
      dist_q <= distance_i;
    end
    case (cmd_i.op)
      OP_INIT:    sum_q <= '0;
      OP_SUM_ACC: sum_q <= sum_q + SUM_W'(w_rd_s);
      OP_AVG_WR:  sum_q <= '0;
      OP_RI_LD:   ri_q  <= a_rd_s;
      OP_Q_CMP: begin
        if (cmd_i.first || (q_val < best_q)) begin
          best_q <= q_val;
          pi_q   <= cmd_i.i;
          pj_q   <= cmd_i.j;
          rpi_q  <= ri_q;
          rpj_q  <= a_rd_s;
        end
      end
      OP_DIJ_LD: dij_q   <= w_rd_s;
      OP_LAB_A:  lab_a_q <= lab_mux;
      OP_BR:     dik_q   <= br_val;
      OP_ND_LD1: t_q     <= w_rd_s;
      OP_FINAL_SEL: begin
        pi_q <= '0;
        pj_q <= IDX_W'(1);
      end
      OP_EMIT: begin
        node_a_o        <= lab_a_q;
        node_b_o        <= lab_mux;
        pair_distance_o <= dij_q;
        branch_a_o      <= sat_val(dik_q);
        branch_b_o      <= sat_val(WIDE_W'(dij_q) - dik_q);
        last_o          <= 1'b0;
      end
      OP_EMIT_LAST: begin
        node_a_o        <= lab_a_q;
        node_b_o        <= lab_mux;
        pair_distance_o <= dij_q;
        branch_a_o      <= '0;
        branch_b_o      <= '0;
        last_o          <= 1'b1;
      end
      default: ;
    endcase
  end

  njt_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (cmd_i.op == OP_DIV_START),
    .dividend_i (sum_q),
    .divisor_i  (km2),
    .busy_o     (div_busy),
    .quot_o     (quot)
  );

  njt_ram #(.WIDTH(VAL_W), .DEPTH(MAX_SEQS * MAX_SEQS)) u_dist_ram (
    .clk_i (clk_i), .we_i (d_we), .waddr_i (d_waddr), .wdata_i (d_wdata),
    .re_i (d_re), .raddr_i (d_raddr), .rdata_o (d_rdata)
  );

  njt_ram #(.WIDTH(VAL_W), .DEPTH(MAX_SEQS * MAX_SEQS)) u_work_ram (
    .clk_i (clk_i), .we_i (w_we), .waddr_i (w_waddr), .wdata_i (w_wdata),
    .re_i (w_re), .raddr_i (w_raddr), .rdata_o (w_rdata)
  );

  njt_ram #(.WIDTH(SUM_W), .DEPTH(MAX_SEQS)) u_avg_ram (
    .clk_i (clk_i), .we_i (a_we), .waddr_i (a_waddr), .wdata_i (quot),
    .re_i (a_re), .raddr_i (a_raddr), .rdata_o (a_rdata)
  );

  njt_ram #(.WIDTH(VAL_W), .DEPTH(MAX_SEQS)) u_node_ram (
    .clk_i (clk_i), .we_i (n_we), .waddr_i (n_waddr), .wdata_i (n_wdata),
    .re_i (n_re), .raddr_i (n_raddr), .rdata_o (n_rdata)
  );

  assign status_o.div_busy = div_busy;
  assign status_o.out_free = !out_valid_o || out_ready_i;
  assign status_o.out_busy = out_valid_o;

endmodule

`default_nettype wire

### rtl/core/njt_ctrl.sv
// ----------------------------------------------------------------------------
// njt_ctrl
// joining tree sequencer: walks load, copy and the passes of every round
// ----------------------------------------------------------------------------
`default_nettype none

module njt_ctrl (
  input  wire logic                      clk_i,
  input  wire logic                      rst_ni,
  input  wire logic                      cfg_we_i,
  input  wire logic [njt_pkg::CNT_W-1:0] cfg_wdata_i,
  input  wire logic                      in_valid_i,
  output      logic                      in_ready_o,
  input  wire logic                      action_i,
  input  wire logic [njt_pkg::IDX_W-1:0] row_i,
  input  wire logic [njt_pkg::IDX_W-1:0] col_i,
  output      njt_pkg::cmd_t             cmd_o,
  input  wire njt_pkg::status_t          status_i
);
  import njt_pkg::*;

  typedef enum logic [5:0] {
    S_IDLE, S_LD_A, S_LD_B, S_INIT, S_CP_RD, S_CP_WR, S_ROUND, S_SUM_RD,
    S_SUM_ACC, S_DIV, S_DIV_WAIT, S_AVG_WR, S_RI_RD, S_RI_LD, S_Q_RD,
    S_Q_CMP, S_DIJ_RD, S_DIJ_LD, S_LAB_A, S_BR, S_EMIT, S_ND_RD1, S_ND_LD1,
    S_ND_RD2, S_ND_WR, S_CMP_RD, S_CMP_WR, S_LAB_SH, S_NN_RD, S_NN_WR1,
    S_NN_WR2, S_DIAG, S_F_SEL, S_F_DIJ_RD, S_F_DIJ_LD, S_F_LAB_A, S_F_EMIT
  } state_e;

  state_e           state_q;
  logic [IDX_W-1:0] i_q, j_q;
  logic [CNT_W-1:0] k_q, seq_count_q, n_clamp, km1, km3, jn;
  logic             last_i, last_j, end_i3, end_j3, in_accept;

  assign n_clamp = (seq_count_q < CNT_W'(MIN_SEQS)) ? CNT_W'(MIN_SEQS) :
                   (seq_count_q > CNT_W'(MAX_SEQS)) ? CNT_W'(MAX_SEQS) : seq_count_q;
  assign km1    = k_q - 1'b1;
  assign km3    = k_q - CNT_W'(3);
  assign last_i = {1'b0, i_q} == km1;
  assign last_j = {1'b0, j_q} == km1;
  assign end_i3 = {1'b0, i_q} == km3;
  assign end_j3 = {1'b0, j_q} == km3;

  // next column of the minimum search, stepping over the diagonal
  always_comb begin
    jn = {1'b0, j_q} + 1'b1;
    if (jn == {1'b0, i_q}) begin
      jn = jn + 1'b1;
    end
  end

  assign in_ready_o = (state_q == S_IDLE) && (!action_i || !status_i.out_busy);
  assign in_accept  = in_valid_i && in_ready_o;

  always_comb begin
    cmd_o.i     = i_q;
    cmd_o.j     = j_q;
    cmd_o.k     = k_q;
    cmd_o.first = (i_q == '0) && (j_q == IDX_W'(1));
    case (state_q)
      S_LD_A:     cmd_o.op = OP_LOAD_A;
      S_LD_B:     cmd_o.op = OP_LOAD_B;
      S_INIT:     cmd_o.op = OP_INIT;
      S_CP_RD:    cmd_o.op = OP_COPY_RD;
      S_CP_WR:    cmd_o.op = OP_COPY_WR;
      S_SUM_RD:   cmd_o.op = OP_SUM_RD;
      S_SUM_ACC:  cmd_o.op = OP_SUM_ACC;
      S_DIV:      cmd_o.op = OP_DIV_START;
      S_AVG_WR:   cmd_o.op = OP_AVG_WR;
      S_RI_RD:    cmd_o.op = OP_RI_RD;
      S_RI_LD:    cmd_o.op = OP_RI_LD;
      S_Q_RD:     cmd_o.op = OP_Q_RD;
      S_Q_CMP:    cmd_o.op = OP_Q_CMP;
      S_DIJ_RD, S_F_DIJ_RD: cmd_o.op = OP_DIJ_RD;
      S_DIJ_LD, S_F_DIJ_LD: cmd_o.op = OP_DIJ_LD;
      S_LAB_A, S_F_LAB_A:   cmd_o.op = OP_LAB_A;
      S_BR:       cmd_o.op = OP_BR;
      S_EMIT:     cmd_o.op = status_i.out_free ? OP_EMIT : OP_NONE;
      S_F_EMIT:   cmd_o.op = status_i.out_free ? OP_EMIT_LAST : OP_NONE;
      S_ND_RD1:   cmd_o.op = OP_ND_RD1;
      S_ND_LD1:   cmd_o.op = OP_ND_LD1;
      S_ND_RD2:   cmd_o.op = OP_ND_RD2;
      S_ND_WR:    cmd_o.op = OP_ND_WR;
      S_CMP_RD:   cmd_o.op = OP_CMP_RD;
      S_CMP_WR:   cmd_o.op = OP_CMP_WR;
      S_LAB_SH:   cmd_o.op = OP_LAB_SHIFT;
      S_NN_RD:    cmd_o.op = OP_NN_RD;
      S_NN_WR1:   cmd_o.op = OP_NN_WR1;
      S_NN_WR2:   cmd_o.op = OP_NN_WR2;
      S_DIAG:     cmd_o.op = OP_DIAG;
      S_F_SEL:    cmd_o.op = OP_FINAL_SEL;
      default:    cmd_o.op = OP_NONE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      i_q         <= '0;
      j_q         <= '0;
      k_q         <= CNT_W'(RESET_SEQS);
      seq_count_q <= CNT_W'(RESET_SEQS);
    end else begin
      if (cfg_we_i) begin
        seq_count_q <= cfg_wdata_i;
      end
      case (state_q)
        S_IDLE: begin
          if (in_accept) begin
            if (action_i) begin
              k_q     <= n_clamp;
              i_q     <= '0;
              j_q     <= '0;
              state_q <= S_INIT;
            end else if (row_i != col_i) begin
              state_q <= S_LD_A;
            end
          end
        end
        S_LD_A:  state_q <= S_LD_B;
        S_LD_B:  state_q <= S_IDLE;
        S_INIT:  state_q <= S_CP_RD;
        S_CP_RD: state_q <= S_CP_WR;
        S_CP_WR: begin
          state_q <= S_CP_RD;
          if (last_j) begin
            j_q <= '0;
            if (last_i) begin
              i_q     <= '0;
              state_q <= S_ROUND;
            end else begin
              i_q <= i_q + 1'b1;
            end
          end else begin
            j_q <= j_q + 1'b1;
          end
        end
        S_ROUND: begin
          i_q <= '0;
          j_q <= '0;
          state_q <= (k_q > CNT_W'(2)) ? S_SUM_RD : S_F_SEL;
        end
        S_SUM_RD: state_q <= S_SUM_ACC;
        S_SUM_ACC: begin
          if (last_j) begin
            j_q     <= '0;
            state_q <= S_DIV;
          end else begin
            j_q     <= j_q + 1'b1;
            state_q <= S_SUM_RD;
          end
        end
        S_DIV: state_q <= S_DIV_WAIT;
        S_DIV_WAIT: begin
          if (!status_i.div_busy) begin
            state_q <= S_AVG_WR;
          end
        end
        S_AVG_WR: begin
          if (last_i) begin
            i_q     <= '0;
            state_q <= S_RI_RD;
          end else begin
            i_q     <= i_q + 1'b1;
            state_q <= S_SUM_RD;
          end
        end
        S_RI_RD: state_q <= S_RI_LD;
        S_RI_LD: begin
          j_q     <= (i_q == '0) ? IDX_W'(1) : '0;
          state_q <= S_Q_RD;
        end
        S_Q_RD: state_q <= S_Q_CMP;
        S_Q_CMP: begin
          if (jn >= k_q) begin
            if (last_i) begin
              state_q <= S_DIJ_RD;
            end else begin
              i_q     <= i_q + 1'b1;
              state_q <= S_RI_RD;
            end
          end else begin
            j_q     <= jn[IDX_W-1:0];
            state_q <= S_Q_RD;
          end
        end
        S_DIJ_RD: state_q <= S_DIJ_LD;
        S_DIJ_LD: state_q <= S_LAB_A;
        S_LAB_A:  state_q <= S_BR;
        S_BR:     state_q <= S_EMIT;
        S_EMIT: begin
          if (status_i.out_free) begin
            i_q     <= '0;
            state_q <= S_ND_RD1;
          end
        end
        S_ND_RD1: state_q <= S_ND_LD1;
        S_ND_LD1: state_q <= S_ND_RD2;
        S_ND_RD2: state_q <= S_ND_WR;
        S_ND_WR: begin
          if (last_i) begin
            i_q     <= '0;
            j_q     <= '0;
            state_q <= S_CMP_RD;
          end else begin
            i_q     <= i_q + 1'b1;
            state_q <= S_ND_RD1;
          end
        end
        S_CMP_RD: state_q <= S_CMP_WR;
        S_CMP_WR: begin
          state_q <= S_CMP_RD;
          if (end_j3) begin
            j_q <= '0;
            if (end_i3) begin
              i_q     <= '0;
              state_q <= S_LAB_SH;
            end else begin
              i_q <= i_q + 1'b1;
            end
          end else begin
            j_q <= j_q + 1'b1;
          end
        end
        S_LAB_SH: state_q <= S_NN_RD;
        S_NN_RD:  state_q <= S_NN_WR1;
        S_NN_WR1: state_q <= S_NN_WR2;
        S_NN_WR2: begin
          if (end_i3) begin
            state_q <= S_DIAG;
          end else begin
            i_q     <= i_q + 1'b1;
            state_q <= S_NN_RD;
          end
        end
        S_DIAG: begin
          k_q     <= k_q - 1'b1;
          state_q <= S_ROUND;
        end
        S_F_SEL:    state_q <= S_F_DIJ_RD;
        S_F_DIJ_RD: state_q <= S_F_DIJ_LD;
        S_F_DIJ_LD: state_q <= S_F_LAB_A;
        S_F_LAB_A:  state_q <= S_F_EMIT;
        S_F_EMIT: begin
          if (status_i.out_free) begin
            state_q <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

endmodule

`default_nettype wire

### rtl/core/neighbor_joining_tree.sv
// ----------------------------------------------------------------------------
// neighbor_joining_tree
// loads a symmetric distance matrix and emits the joins of neighbor joining
// ----------------------------------------------------------------------------
//  channel  | handshake                 | payload
//  ---------+---------------------------+-------------------------------------
//  in       | in_valid_i / in_ready_o   | action_i row_i col_i distance_i
//  out      | out_valid_o / out_ready_i | node_a_o node_b_o pair_distance_o
//           |                           | branch_a_o branch_b_o last_o
//  cfg      | cfg_we_i                  | cfg_wdata_i (sequence count)
//
//  a load beat makes two writes into the single write port of the distance
//  ram, the entry and its mirror. a run with n sequences first copies the
//  n x n matrix into the working ram, then for each round of k active nodes
//  reads each matrix element through the one read port of the working ram
//  and waits on the serial divider for every row average.
//  no clearing pass after reset. a stalled output beat holds the run in place.
// ----------------------------------------------------------------------------
`default_nettype none

module neighbor_joining_tree (
  input  wire logic                              clk_i,
  input  wire logic                              rst_ni,
  input  wire logic                              cfg_we_i,
  input  wire logic [njt_pkg::CNT_W-1:0]         cfg_wdata_i,
  input  wire logic                              in_valid_i,
  output      logic                              in_ready_o,
  input  wire logic                              action_i,
  input  wire logic [njt_pkg::IDX_W-1:0]         row_i,
  input  wire logic [njt_pkg::IDX_W-1:0]         col_i,
  input  wire logic [njt_pkg::DIST_BITS-1:0]     distance_i,
  output      logic                              out_valid_o,
  input  wire logic                              out_ready_i,
  output      logic [njt_pkg::LAB_W-1:0]         node_a_o,
  output      logic [njt_pkg::LAB_W-1:0]         node_b_o,
  output      logic signed [njt_pkg::VAL_W-1:0]  pair_distance_o,
  output      logic signed [njt_pkg::VAL_W-1:0]  branch_a_o,
  output      logic signed [njt_pkg::VAL_W-1:0]  branch_b_o,
  output      logic                              last_o
);
  import njt_pkg::*;

  cmd_t    cmd;
  status_t status;

  njt_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .action_i    (action_i),
    .row_i       (row_i),
    .col_i       (col_i),
    .cmd_o       (cmd),
    .status_i    (status)
  );

  njt_dp u_dp (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cmd_i           (cmd),
    .status_o        (status),
    .in_accept_i     (in_valid_i && in_ready_o),
    .row_i           (row_i),
    .col_i           (col_i),
    .distance_i      (distance_i),
    .out_ready_i     (out_ready_i),
    .out_valid_o     (out_valid_o),
    .node_a_o        (node_a_o),
    .node_b_o        (node_b_o),
    .pair_distance_o (pair_distance_o),
    .branch_a_o      (branch_a_o),
    .branch_b_o      (branch_b_o),
    .last_o          (last_o)
  );

endmodule

`default_nettype wire

### rtl/core/njt_checker.sv
// ----------------------------------------------------------------------------
// njt_checker
// port level checks of the joining tree, bound to the top level
// ----------------------------------------------------------------------------
`default_nettype none
`include "neighbor_joining_tree_defines.svh"

module njt_checker (
  input wire logic                              clk_i,
  input wire logic                              rst_ni,
  input wire logic                              cfg_we_i,
  input wire logic [njt_pkg::CNT_W-1:0]         cfg_wdata_i,
  input wire logic                              in_valid_i,
  input wire logic                              in_ready_o,
  input wire logic                              action_i,
  input wire logic [njt_pkg::IDX_W-1:0]         row_i,
  input wire logic [njt_pkg::IDX_W-1:0]         col_i,
  input wire logic [njt_pkg::DIST_BITS-1:0]     distance_i,
  input wire logic                              out_valid_o,
  input wire logic                              out_ready_i,
  input wire logic [njt_pkg::LAB_W-1:0]         node_a_o,
  input wire logic [njt_pkg::LAB_W-1:0]         node_b_o,
  input wire logic signed [njt_pkg::VAL_W-1:0]  pair_distance_o,
  input wire logic signed [njt_pkg::VAL_W-1:0]  branch_a_o,
  input wire logic signed [njt_pkg::VAL_W-1:0]  branch_b_o,
  input wire logic                              last_o
);

  // a run never starts while an earlier beat is still waiting
  `NJT_ASSERT_NOW(run_needs_free_out, clk_i, rst_ni, in_valid_i && in_ready_o && action_i, !out_valid_o)
  // a run blocks the input side at least in the next cycle
  `NJT_ASSERT_NEXT(run_blocks_input, clk_i, rst_ni, in_valid_i && in_ready_o && action_i, !in_ready_o)
  // the closing join carries no branch lengths
  `NJT_ASSERT_NOW(last_zero_branch, clk_i, rst_ni, out_valid_o && last_o, branch_a_o == '0 && branch_b_o == '0)
  // a stalled beat keeps its labels
  `NJT_ASSERT_NEXT(out_holds, clk_i, rst_ni, out_valid_o && !out_ready_i, out_valid_o && $stable(node_a_o) && $stable(node_b_o))

endmodule

bind neighbor_joining_tree njt_checker u_njt_checker (.*);

`default_nettype wire
